// ===== rtl/twm_pkg.sv =====
`default_nettype none

package twm_pkg;

	// table geometry
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int KEY_W   = 32;
	localparam int ENTRY_W = 2 * KEY_W;	// {handle, remote id}
	localparam int STAT_W  = 3;
	localparam int OCNT_W  = 7;

	// request codes
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DEL    = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_APPENDED = 3'd0;
	localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_FOUND    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [STAT_W-1:0] ST_DELETED  = 3'd5;
	localparam logic [STAT_W-1:0] ST_DELMISS  = 3'd6;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [ADDR_W-1:0]  raddr;
	} ram_cmd_t;

	typedef struct packed {
		logic              vld;
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  found_handle;
		logic [OCNT_W-1:0] entry_count;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/twm_ram.sv =====
`default_nettype none

module twm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/twm_ctrl.sv =====
`default_nettype none

module twm_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                req_type,
	input  wire logic [twm_pkg::KEY_W-1:0] local_handle,
	input  wire logic [twm_pkg::KEY_W-1:0] remote_id,
	output twm_pkg::ram_cmd_t              ram_cmd,
	input  wire logic [twm_pkg::ENTRY_W-1:0] ram_rdata,
	output twm_pkg::res_t                  res,
	input  wire logic                      res_ack
);
	import twm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DRD  = 3'd2;
	localparam logic [2:0] S_DWR  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [1:0]        req_q;
	logic [KEY_W-1:0]  hnd_q;
	logic [KEY_W-1:0]  rid_q;
	logic [CNT_W-1:0]  idx_q;
	logic              cmp_vld_q;
	logic [ADDR_W-1:0] cmp_idx_q;
	logic [ADDR_W-1:0] del_idx_q;
	logic [CNT_W-1:0]  fill_q;
	logic [STAT_W-1:0] status_q;
	logic [KEY_W-1:0]  found_q;

	logic [KEY_W-1:0]  rd_hnd;
	logic [KEY_W-1:0]  rd_rid;
	logic [KEY_W-1:0]  cmp_a;
	logic [KEY_W-1:0]  cmp_b;
	logic              hit;
	logic              issue_more;
	logic              room;
	logic [ADDR_W-1:0] last_addr;

	assign rd_hnd     = ram_rdata[ENTRY_W-1 -: KEY_W];
	assign rd_rid     = ram_rdata[KEY_W-1:0];
	// the one comparator: remote id for lookups, handle otherwise
	assign cmp_a      = (req_q == REQ_LOOKUP) ? rd_rid : rd_hnd;
	assign cmp_b      = (req_q == REQ_LOOKUP) ? rid_q : hnd_q;
	assign hit        = cmp_vld_q && (cmp_a == cmp_b);
	assign issue_more = idx_q < fill_q;
	assign room       = fill_q < CNT_W'(DEPTH);
	assign last_addr  = ADDR_W'(fill_q - CNT_W'(1));

	assign in_stall        = (state_q != S_IDLE);
	assign res.vld          = (state_q == S_DONE);
	assign res.status       = status_q;
	assign res.found_handle = found_q;
	assign res.entry_count  = OCNT_W'(fill_q);

	always_comb begin
		ram_cmd.we    = 1'b0;
		ram_cmd.waddr = cmp_idx_q;
		ram_cmd.wdata = {hnd_q, rid_q};
		ram_cmd.raddr = idx_q[ADDR_W-1:0];
		unique case (state_q)
			S_SCAN: begin
				if (req_q == REQ_ADD) begin
					if (hit) begin
						ram_cmd.we = 1'b1;
					end else if (!issue_more && room) begin
						ram_cmd.we    = 1'b1;
						ram_cmd.waddr = fill_q[ADDR_W-1:0];
					end
				end
			end
			S_DRD: begin
				ram_cmd.raddr = last_addr;
			end
			S_DWR: begin
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = del_idx_q;
				ram_cmd.wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= REQ_NONE;
			hnd_q     <= '0;
			rid_q     <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			cmp_idx_q <= '0;
			del_idx_q <= '0;
			fill_q    <= '0;
			status_q  <= ST_NOTFOUND;
			found_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q     <= req_type;
						hnd_q     <= local_handle;
						rid_q     <= remote_id;
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						found_q   <= '0;
						if (req_type == REQ_NONE) begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// read slot idx_q, compare the slot read last cycle
					cmp_vld_q <= issue_more;
					cmp_idx_q <= idx_q[ADDR_W-1:0];
					if (issue_more) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (hit) begin
						unique case (req_q)
							REQ_ADD: begin
								status_q <= ST_UPDATED;
								state_q  <= S_DONE;
							end
							REQ_LOOKUP: begin
								status_q <= ST_FOUND;
								found_q  <= rd_hnd;
								state_q  <= S_DONE;
							end
							REQ_DEL: begin
								del_idx_q <= cmp_idx_q;
								state_q   <= S_DRD;
							end
							default: begin
								status_q <= ST_NOTFOUND;
								state_q  <= S_DONE;
							end
						endcase
					end else if (!issue_more) begin
						state_q <= S_DONE;
						unique case (req_q)
							REQ_ADD: begin
								if (room) begin
									fill_q   <= fill_q + CNT_W'(1);
									status_q <= ST_APPENDED;
								end else begin
									status_q <= ST_FULL;
								end
							end
							REQ_DEL:    status_q <= ST_DELMISS;
							default:    status_q <= ST_NOTFOUND;
						endcase
					end
				end
				S_DRD: begin
					state_q <= S_DWR;
				end
				S_DWR: begin
					fill_q   <= fill_q - CNT_W'(1);
					status_q <= ST_DELETED;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_fill_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |-> ($past(state_q) == S_SCAN || $past(state_q) == S_DWR))
		else $error("fill count moved outside append or delete");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted word left no work");

	a_del_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DWR) |-> (CNT_W'(del_idx_q) < fill_q))
		else $error("delete slot outside table");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && (status_q != ST_FOUND)) |-> (found_q == '0))
		else $error("handle returned without a match");

endmodule

`default_nettype wire

// ===== rtl/two_key_window_map_table.sv =====
`default_nettype none

// channel  dir  handshake         fields
// in       in   in_valid/in_stall  req_type, local_handle, remote_id
// out      out  out_valid/out_stall status, found_handle, entry_count
//
// One request is worked at a time: the scan reads the filled slots from slot 0 until a
// match, and a delete that hits then reads the last slot and moves it into the hole.
// The table RAM has a single read port, so the scan reads one slot a cycle.
// arst_n clears the sequencer, the fill count and the output valid flag; RAM contents
// are left as they are and only slots below the fill count are ever compared.
// The output register lets the next request in while a result word waits on out_stall.

module two_key_window_map_table (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                req_type,
	input  wire logic [twm_pkg::KEY_W-1:0] local_handle,
	input  wire logic [twm_pkg::KEY_W-1:0] remote_id,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [twm_pkg::STAT_W-1:0]     status,
	output logic [twm_pkg::KEY_W-1:0]      found_handle,
	output logic [twm_pkg::OCNT_W-1:0]     entry_count
);
	import twm_pkg::*;

	ram_cmd_t           ram_cmd;
	logic [ENTRY_W-1:0] ram_rdata;
	res_t               res;
	logic               res_ack;

	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [KEY_W-1:0]   found_handle_q;
	logic [OCNT_W-1:0]  entry_count_q;

	// sequencer with the shared key comparator
	twm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.local_handle (local_handle),
		.remote_id    (remote_id),
		.ram_cmd      (ram_cmd),
		.ram_rdata    (ram_rdata),
		.res          (res),
		.res_ack      (res_ack)
	);

	// both stores share one row: {handle, remote id}
	twm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_cmd.we),
		.waddr (ram_cmd.waddr),
		.wdata (ram_cmd.wdata),
		.raddr (ram_cmd.raddr),
		.rdata (ram_rdata)
	);

	// result word loads when the register is empty or being drained
	assign res_ack = res.vld && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			status_q       <= res.status;
			found_handle_q <= res.found_handle;
			entry_count_q  <= res.entry_count;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_handle = found_handle_q;
	assign entry_count  = entry_count_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Request/answer check of the window map table.
// Requests go in on the input channel one word at a time; a local copy of the
// table predicts each answer word, which is queued on acceptance and compared
// field by field when the answer word is taken on the output channel.

module testbench;
	import twm_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;	// cycles with no word moving on either side
	localparam int HOLD_OFF_CYCLES = 600;	// long receiver stall for the back-pressure test
	localparam int DRAIN_CYCLES    = 100;	// > worst latency of one request
	localparam int HANDLE_POOL_N   = 96;	// more handles than slots, so the table fills
	localparam int REMOTE_POOL_N   = 48;	// fewer remote ids than slots, so ids repeat

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  found_handle;
		logic [OCNT_W-1:0] entry_count;
	} map_answer_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        req_type;
	logic [KEY_W-1:0]  local_handle;
	logic [KEY_W-1:0]  remote_id;
	logic              out_valid;
	logic              out_stall;
	logic [STAT_W-1:0] status;
	logic [KEY_W-1:0]  found_handle;
	logic [OCNT_W-1:0] entry_count;

	// shadow copy of the table: slots below map_fill are live, no holes
	logic [KEY_W-1:0]  map_handle [DEPTH];
	logic [KEY_W-1:0]  map_remote [DEPTH];
	int                map_fill;

	map_answer_t       pending_answers [$];	// answers owed, oldest first
	int                mismatches;
	int                quiet_cycles;
	int                hold_left;		// receiver hold-off still to run, in cycles
	bit                no_idle;		// both sides run flat out while set
	logic [KEY_W-1:0]  handle_pool [HANDLE_POOL_N];
	logic [KEY_W-1:0]  remote_pool [REMOTE_POOL_N];

	two_key_window_map_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.local_handle (local_handle),
		.remote_id    (remote_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.found_handle (found_handle),
		.entry_count  (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Table prediction
	// ---------------------------------------------------------------

	// slot holding handle h, or -1 when it is not in the table
	function automatic int slot_of_handle(logic [KEY_W-1:0] h);
		for (int i = 0; i < map_fill; i++)
			if (map_handle[i] == h)
				return i;
		return -1;
	endfunction

	// applies one request to the shadow table and returns the answer it owes
	function automatic map_answer_t apply_request(logic [1:0] req, logic [KEY_W-1:0] h,
			logic [KEY_W-1:0] r);
		map_answer_t ans;
		int          slot;
		ans.status       = ST_NOTFOUND;	// also the answer to the unused request code
		ans.found_handle = '0;
		case (req)
			REQ_ADD: begin
				slot = slot_of_handle(h);
				if (slot >= 0) begin
					map_remote[slot] = r;
					ans.status = ST_UPDATED;
				end else if (map_fill < DEPTH) begin
					map_handle[map_fill] = h;
					map_remote[map_fill] = r;
					map_fill++;
					ans.status = ST_APPENDED;
				end else begin
					ans.status = ST_FULL;
				end
			end
			REQ_LOOKUP: begin
				// first match in slot order wins when remote ids repeat
				for (int i = 0; i < map_fill; i++) begin
					if (map_remote[i] == r) begin
						ans.status       = ST_FOUND;
						ans.found_handle = map_handle[i];
						break;
					end
				end
			end
			REQ_DEL: begin
				slot = slot_of_handle(h);
				if (slot >= 0) begin
					// last entry fills the hole; on the last slot it moves onto itself
					map_handle[slot] = map_handle[map_fill-1];
					map_remote[slot] = map_remote[map_fill-1];
					map_fill--;
					ans.status = ST_DELETED;
				end else begin
					ans.status = ST_DELMISS;
				end
			end
			default: begin
			end
		endcase
		ans.entry_count = OCNT_W'(map_fill);
		return ans;
	endfunction

	task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
		mismatches++;
		$display("%0t ns: %s mismatch, got %h, expected %h", $realtime, what, got, want);
	endtask

	// ---------------------------------------------------------------
	// Monitor: predict on request acceptance, check on answer acceptance.
	// Both handshakes are sampled at the rising edge, before the block's
	// own register updates land.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		map_answer_t want;
		bit          moved;
		moved = 1'b0;
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected answer word, status", KEY_W'(status), '0);
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.status)
					report_mismatch("status", KEY_W'(status), KEY_W'(want.status));
				if (found_handle !== want.found_handle)
					report_mismatch("found_handle", found_handle, want.found_handle);
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", KEY_W'(entry_count),
						KEY_W'(want.entry_count));
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			moved = 1'b1;
			pending_answers.push_back(apply_request(req_type, local_handle, remote_id));
		end
		// watchdog: a hung handshake on either side ends the run
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Receiver: a random stall ahead of each answer word,
	// plus the long hold-off when the back-pressure test asks for one.
	// ---------------------------------------------------------------
	initial begin
		int  stall_left;
		bit  taken;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			taken = out_valid && !out_stall;
			if (taken)
				stall_left = no_idle ? 0 : $urandom_range(0, 7);
			else if (out_valid && stall_left > 0)
				stall_left--;
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = (stall_left > 0);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender: called just after a falling edge, returns just after the
	// falling edge that follows acceptance. Valid stays high when the
	// next word follows with no gap.
	// ---------------------------------------------------------------
	task automatic send_word(logic [1:0] req, logic [KEY_W-1:0] h, logic [KEY_W-1:0] r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type     = req;
		local_handle = h;
		remote_id    = r;
		in_valid     = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// one request drawn from the pools, weighted by operation
	task automatic send_random(int add_pct, int del_pct);
		logic [1:0]       req;
		logic [KEY_W-1:0] h;
		logic [KEY_W-1:0] r;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < add_pct)
			req = REQ_ADD;
		else if (pick < add_pct + del_pct)
			req = REQ_DEL;
		else if (pick < 96)
			req = REQ_LOOKUP;
		else
			req = REQ_NONE;
		// mostly pooled keys so that hits are common; the odd fresh one misses
		h = ($urandom_range(0, 9) == 0) ? $urandom()
			: handle_pool[$urandom_range(0, HANDLE_POOL_N-1)];
		r = ($urandom_range(0, 9) == 0) ? $urandom()
			: remote_pool[$urandom_range(0, REMOTE_POOL_N-1)];
		send_word(req, h, r);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// empty table, key extremes, update, duplicate remote ids, both delete cases,
	// unused request code; leaves the table empty
	task automatic test_directed();
		send_word(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);	// lookup on empty
		send_word(REQ_DEL,    32'hFFFF_FFFF, 32'h0000_0000);	// delete on empty
		send_word(REQ_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);	// unused code, empty table
		send_word(REQ_ADD,    32'h0000_0000, 32'h0000_0000);
		send_word(REQ_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(REQ_ADD,    32'hA5A5_A5A5, 32'hFFFF_FFFF);	// same remote id twice
		send_word(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);	// lowest slot must win
		send_word(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);	// found, handle is zero
		send_word(REQ_ADD,    32'h0000_0000, 32'h5A5A_5A5A);	// update in place
		send_word(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);	// old id gone
		send_word(REQ_LOOKUP, 32'h0000_0000, 32'h5A5A_5A5A);
		send_word(REQ_NONE,   32'h1234_5678, 32'h5A5A_5A5A);	// unused code, full fields
		send_word(REQ_DEL,    32'hA5A5_A5A5, 32'h0000_0000);	// delete of the last slot
		send_word(REQ_DEL,    32'h0000_0000, 32'hFFFF_FFFF);	// slot 0, last entry moves in
		send_word(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);	// moved entry still found
		send_word(REQ_DEL,    32'h0000_0000, 32'h0000_0000);	// already gone
		send_word(REQ_ADD,    32'h8000_0001, 32'h7FFF_FFFE);
		send_word(REQ_ADD,    32'h7FFF_FFFE, 32'h8000_0001);
		send_word(REQ_LOOKUP, 32'h0000_0000, 32'h8000_0001);
		send_word(REQ_DEL,    32'hFFFF_FFFF, 32'h0000_0000);
		send_word(REQ_DEL,    32'h7FFF_FFFE, 32'h0000_0000);
		send_word(REQ_DEL,    32'h8000_0001, 32'h0000_0000);	// table empty again
	endtask

	// fill every slot, then push past the end
	task automatic test_table_full();
		for (int i = 0; i < DEPTH; i++)
			send_word(REQ_ADD, handle_pool[i], remote_pool[i % REMOTE_POOL_N]);
		send_word(REQ_ADD, handle_pool[DEPTH], 32'h0000_0000);	// dropped
		send_word(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(REQ_ADD, handle_pool[DEPTH-1], 32'hFFFF_FFFF);	// update still works
		send_word(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(REQ_LOOKUP, 32'h0000_0000, remote_pool[(DEPTH-1) % REMOTE_POOL_N]);
		send_word(REQ_DEL, handle_pool[0], 32'h0000_0000);
		send_word(REQ_ADD, handle_pool[DEPTH+1], 32'h0000_0000);	// room again
		send_word(REQ_ADD, handle_pool[DEPTH+2], 32'h0000_0000);	// full again
	endtask

	task automatic test_random(int count, int add_pct, int del_pct);
		repeat (count)
			send_random(add_pct, del_pct);
	endtask

	// receiver holds off for a long stretch while requests keep coming, so the
	// output register fills and the block stalls its input
	task automatic test_backpressure();
		hold_left = HOLD_OFF_CYCLES;
		repeat (24)
			send_random(45, 25);
	endtask

	// no gaps and no stalls: requests back to back
	task automatic test_back_to_back();
		no_idle = 1'b1;
		test_random(250, 45, 30);
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		req_type     = REQ_NONE;
		local_handle = '0;
		remote_id    = '0;
		no_idle      = 1'b0;
		hold_left    = 0;
		mismatches   = 0;
		quiet_cycles = 0;
		map_fill     = 0;
		foreach (handle_pool[i])
			handle_pool[i] = $urandom();
		foreach (remote_pool[i])
			remote_pool[i] = $urandom();
		handle_pool[1]  = 32'h0000_0000;
		handle_pool[2]  = 32'hFFFF_FFFF;
		remote_pool[3]  = 32'h0000_0000;
		remote_pool[4]  = 32'hFFFF_FFFF;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_table_full();
		test_random(450, 45, 25);	// mixed, table mostly near full
		test_random(200, 15, 60);	// delete heavy, drains the table
		test_backpressure();
		test_back_to_back();
		test_random(250, 55, 20);	// refill

		in_valid = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
